// ===== rtl/sbsm_pkg.sv =====
// Shared types, constants and helpers for the serial bank switch mapper.
package sbsm_pkg;

    localparam int ADDR_W        = 16;
    localparam int DATA_W        = 8;
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 32;
    localparam int OUT_FIELDS_W  = 25;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 7;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANKS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHR_ROM    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRAM_MODE  = 2'd2;

    // internal register selected by address bits 14:13
    localparam logic [1:0] REG_CONTROL  = 2'd0;
    localparam logic [1:0] REG_CHR_LOW  = 2'd1;
    localparam logic [1:0] REG_CHR_HIGH = 2'd2;
    localparam logic [1:0] REG_PRG      = 2'd3;

    // work RAM banking modes
    localparam logic [1:0] WRAM_NONE  = 2'd0;
    localparam logic [1:0] WRAM_COUNT = 2'd1;
    localparam logic [1:0] WRAM_REG1  = 2'd2;

    localparam logic [ADDR_W-1:0] WRAM_COUNT_ADDR = 16'hBFFF;
    localparam logic [6:0]        LARGE_BANKS     = 7'd32;
    localparam logic [6:0]        PRG_BANKS_RESET = 7'd8;
    localparam logic [4:0]        CTRL_RESET      = 5'h0C;
    localparam logic [2:0]        SHIFT_LEN       = 3'd5;
    localparam logic [2:0]        WRAM_WRITES     = 3'd5;

    typedef struct packed {
        logic [6:0] prg_banks;
        logic       chr_rom;
        logic [1:0] wram_mode;
    } t_cfg;

    typedef struct packed {
        logic [4:0] ctrl;
        logic [4:0] chr_low;
        logic [4:0] chr_high;
        logic [4:0] prg;
    } t_regs;

    typedef struct packed {
        logic       fire;
        logic [1:0] region;
    } t_commit;

    typedef struct packed {
        logic [5:0] prg_low;
        logic [5:0] prg_high;
        logic [4:0] chr_low;
        logic [4:0] chr_high;
        logic [1:0] mirror;
        logic       wram;
    } t_map;

    // bank at 0xC000 after reset or a size change
    function automatic logic [5:0] reset_high_bank(input logic [6:0] banks);
        logic [6:0] last;
        last = banks - 7'd1;
        if (banks >= LARGE_BANKS) begin
            reset_high_bank = 6'd15;
        end else begin
            reset_high_bank = last[5:0];
        end
    endfunction

endpackage

// ===== rtl/sbsm_shifter.sv =====
// Serial load shifter and the four internal mapper registers.
module sbsm_shifter
    import sbsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_large,
    output t_commit           o_commit,
    output t_regs             o_regs
);

    logic [2:0] r_cnt, n_cnt;
    logic [4:0] r_val, n_val;
    logic [1:0] r_last, n_last;
    t_regs      r_regs, n_regs;
    t_commit    commit;
    logic [1:0] region;

    always_comb begin
        region = i_address[14:13];
        n_cnt  = r_cnt;
        n_val  = r_val;
        n_last = r_last;
        n_regs = r_regs;
        commit = '0;
        if (i_go) begin
            // normal carts restart the sequence when the target register changes
            if (!i_large) begin
                if (region != r_last) begin
                    n_cnt = '0;
                    n_val = '0;
                end
                n_last = region;
            end
            if (i_data[7]) begin
                n_cnt       = '0;
                n_val       = '0;
                n_regs.ctrl = r_regs.ctrl | CTRL_RESET;
            end else begin
                n_val = n_val | (5'(i_data[0]) << n_cnt);
                n_cnt = n_cnt + 3'd1;
                if (n_cnt == SHIFT_LEN) begin
                    case (region)
                        REG_CONTROL:  n_regs.ctrl     = n_val;
                        REG_CHR_LOW:  n_regs.chr_low  = n_val;
                        REG_CHR_HIGH: n_regs.chr_high = n_val;
                        REG_PRG:      n_regs.prg      = n_val;
                        default:      n_regs          = r_regs;
                    endcase
                    n_val         = '0;
                    n_cnt         = '0;
                    commit.fire   = 1'b1;
                    commit.region = region;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_val  <= '0;
            r_last <= '0;
            r_regs <= '{ctrl: CTRL_RESET, default: '0};
        end else begin
            r_cnt  <= n_cnt;
            r_val  <= n_val;
            r_last <= n_last;
            r_regs <= n_regs;
        end
    end

    assign o_commit = commit;
    assign o_regs   = n_regs;

endmodule

// ===== rtl/sbsm_map.sv =====
// Bank map: PRG/CHR banks, mirroring and work RAM bank selection.
module sbsm_map
    import sbsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [ADDR_W-1:0] i_address,
    input  logic              i_bit0,
    input  t_commit           i_commit,
    input  t_regs             i_regs,
    input  t_cfg              i_cfg,
    input  logic              i_large,
    input  logic              i_reload,
    input  logic [6:0]        i_new_banks,
    output t_map              o_map
);

    t_map       r_map, n_map;
    logic [2:0] r_wcnt, n_wcnt;
    logic [2:0] r_wsum, n_wsum;
    logic [4:0] chr_8k_low, chr_8k_high;
    logic [4:0] prg_mask;
    logic       base;

    always_comb begin
        n_map  = r_map;
        n_wcnt = r_wcnt;
        n_wsum = r_wsum;

        chr_8k_low  = i_regs.chr_low & 5'h1E;
        chr_8k_high = i_regs.chr_low | 5'h01;
        base        = i_regs.chr_low[4];
        prg_mask    = {base, 4'hE};

        if (i_reload) begin
            n_map.prg_low  = '0;
            n_map.prg_high = reset_high_bank(i_new_banks);
        end

        if (i_go) begin
            if (i_cfg.wram_mode == WRAM_COUNT && i_address == WRAM_COUNT_ADDR) begin
                n_wcnt = r_wcnt + 3'd1;
                n_wsum = r_wsum + 3'(i_bit0);
                if (n_wcnt == WRAM_WRITES) begin
                    n_map.wram = (n_wsum != 3'd0);
                    n_wcnt     = '0;
                    n_wsum     = '0;
                end
            end

            if (i_commit.fire) begin
                if (!i_large) begin
                    case (i_commit.region)
                        REG_CONTROL: begin
                            n_map.mirror = i_regs.ctrl[1:0];
                        end
                        REG_CHR_LOW, REG_CHR_HIGH: begin
                            if (i_cfg.chr_rom) begin
                                if (i_regs.ctrl[4]) begin
                                    n_map.chr_low  = i_regs.chr_low;
                                    n_map.chr_high = i_regs.chr_high;
                                end else begin
                                    n_map.chr_low  = chr_8k_low;
                                    n_map.chr_high = chr_8k_high;
                                end
                            end else if (i_regs.ctrl[4]) begin
                                // CHR RAM: only the written page moves
                                if (i_commit.region == REG_CHR_LOW) begin
                                    n_map.chr_low = i_regs.chr_low;
                                end else begin
                                    n_map.chr_high = i_regs.chr_high;
                                end
                            end
                        end
                        REG_PRG: begin
                            if (!i_regs.ctrl[3]) begin
                                n_map.prg_low  = {1'b0, i_regs.prg & 5'h1E};
                                n_map.prg_high = {1'b0, i_regs.prg | 5'h01};
                            end else if (i_regs.ctrl[2]) begin
                                n_map.prg_low  = {1'b0, i_regs.prg};
                                n_map.prg_high = 6'(i_cfg.prg_banks - 7'd1);
                            end else begin
                                n_map.prg_low  = '0;
                                n_map.prg_high = {1'b0, i_regs.prg};
                            end
                        end
                        default: n_map = r_map;
                    endcase
                end else begin
                    // large carts: each commit remaps all but mirroring
                    if (i_cfg.wram_mode == WRAM_REG1) begin
                        n_map.wram = |i_regs.chr_low[4:3];
                    end
                    if (i_commit.region == REG_CONTROL) begin
                        n_map.mirror = i_regs.ctrl[1:0];
                    end
                    if (i_regs.ctrl[4]) begin
                        if (i_cfg.chr_rom || i_regs.ctrl[4]) begin
                            n_map.chr_low  = i_regs.chr_low;
                            n_map.chr_high = i_regs.chr_high;
                        end
                    end else if (i_cfg.chr_rom) begin
                        n_map.chr_low  = chr_8k_low;
                        n_map.chr_high = chr_8k_high;
                    end
                    if (!i_regs.ctrl[3]) begin
                        n_map.prg_low  = {1'b0, i_regs.prg & prg_mask};
                        n_map.prg_high = {1'b0, (i_regs.prg & prg_mask) | 5'h01};
                    end else if (i_regs.ctrl[2]) begin
                        n_map.prg_low  = {1'b0, base, i_regs.prg[3:0]};
                        n_map.prg_high = {1'b0, base, 4'hF};
                    end else begin
                        n_map.prg_low  = {1'b0, base, 4'h0};
                        n_map.prg_high = {1'b0, base, i_regs.prg[3:0]};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map  <= '{prg_high: reset_high_bank(PRG_BANKS_RESET),
                        chr_high: 5'd1, default: '0};
            r_wcnt <= '0;
            r_wsum <= '0;
        end else begin
            r_map  <= n_map;
            r_wcnt <= n_wcnt;
            r_wsum <= n_wsum;
        end
    end

    assign o_map = r_map;

endmodule

// ===== rtl/serial_bank_switch_mapper.sv =====
// Top level of the serial bank switch mapper: handshakes, config and stages.
//
// Usage:
//   Slave stream s_axis carries one CPU write to 0x8000-0xFFFF per
//   transaction: tdata[15:0] address, tdata[23:16] data.
//   Master stream m_axis returns one transaction per write with the bank
//   map as it stands after that write.
//   The config channel (i_cfg_valid/o_cfg_ready, index, data) sets ROM size,
//   CHR ROM presence and work RAM mode; o_cfg_ready is always high and
//   writes are expected only while the block is idle.
// Timing:
//   A write is captured in the input register, decoded by one level of
//   shifter and map logic, and its result leaves from the map registers,
//   which take a write only when the output slot is free.
//   One write per cycle is sustained while m_axis_tready stays high; the
//   input register and the output register hold separate transactions.
// Reset: synchronous active-low; clears both stages and loads the power-up
//   bank map (PRG 0 / last, CHR 0 / 1, control 0x0C).
// Stall: while m_axis_tready is low the result is held and one more write
//   waits in the input register; s_axis_tready drops after that.
module serial_bank_switch_mapper
    import sbsm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // address[15:0], data[23:16]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // prg_bank_low[5:0], prg_bank_high[11:6], chr_bank_low[16:12],
    // chr_bank_high[21:17], mirroring[23:22], wram_page[24], zeros above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic              r_in_valid;
    logic [ADDR_W-1:0] r_address;
    logic [DATA_W-1:0] r_data;
    logic              r_out_valid;
    t_cfg              r_cfg;
    logic              advance, go, cfg_wr, reload, large_cart;
    t_commit           commit;
    t_regs             regs;
    t_map              map;

    assign advance       = !r_out_valid || m_axis_tready;
    assign go            = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid && o_cfg_ready;
    assign reload        = cfg_wr && (i_cfg_index == CFG_PRG_BANKS);
    assign large_cart    = r_cfg.prg_banks >= LARGE_BANKS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{prg_banks: PRG_BANKS_RESET, chr_rom: 1'b1, wram_mode: WRAM_NONE};
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_PRG_BANKS: r_cfg.prg_banks <= i_cfg_data;
                CFG_CHR_ROM:   r_cfg.chr_rom   <= i_cfg_data[0];
                CFG_WRAM_MODE: r_cfg.wram_mode <= i_cfg_data[1:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_address <= s_axis_tdata[ADDR_W-1:0];
            r_data    <= s_axis_tdata[ADDR_W +: DATA_W];
        end
    end

    sbsm_shifter u_shifter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .i_address (r_address),
        .i_data    (r_data),
        .i_large   (large_cart),
        .o_commit  (commit),
        .o_regs    (regs)
    );

    sbsm_map u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_address   (r_address),
        .i_bit0      (r_data[0]),
        .i_commit    (commit),
        .i_regs      (regs),
        .i_cfg       (r_cfg),
        .i_large     (large_cart),
        .i_reload    (reload),
        .i_new_banks (i_cfg_data),
        .o_map       (map)
    );

    // map registers: the result payload; writes move them only when the slot is free
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                            map.wram, map.mirror, map.chr_high, map.chr_low,
                            map.prg_high, map.prg_low};

endmodule

// ===== rtl/sbsm_checker.sv =====
// Port-level checker for the serial bank switch mapper, bound to the top level.
module sbsm_checker
    import sbsm_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // a held result keeps its valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // nothing shown the cycle after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    // an accepted write is followed by a showing result after the input and map registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("accepted write produced no result");

    // input back-pressure only comes from a stalled result
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

    // padding bits above the result fields stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] == '0)
        else $error("nonzero padding in result");

endmodule

bind serial_bank_switch_mapper sbsm_checker u_sbsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/serial_bank_switch_mapper_tb.sv =====
// Testbench for the serial bank switch mapper: random CPU writes checked against a bank map model.
`timescale 1ns / 100ps

module serial_bank_switch_mapper_tb;
    import sbsm_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_BAD_INDEX = 2'd3;
    localparam int                     N_PHASES      = 8;
    localparam int                     PHASE_ITEMS   = 219;

    // Tracks the mapper state and holds the bank map expected after each write.
    class bank_map_scoreboard;
        logic [6:0] prg_banks;
        logic       chr_rom;
        logic [1:0] wram_mode;
        logic [2:0] shift_count;
        logic [4:0] shift_value;
        logic [4:0] ctrl;
        logic [4:0] bank_reg [1:3];
        logic [1:0] last_region;
        logic [2:0] wram_hits;
        logic [2:0] wram_sum;
        t_map       map;
        t_map       expected_maps[$];
        int         errors;

        function new();
            prg_banks   = PRG_BANKS_RESET;
            chr_rom     = 1'b1;
            wram_mode   = WRAM_NONE;
            shift_count = '0;
            shift_value = '0;
            ctrl        = CTRL_RESET;
            bank_reg    = '{default: '0};
            last_region = '0;
            wram_hits   = '0;
            wram_sum    = '0;
            map         = '0;
            map.chr_high = 5'd1;
            load_prg_reset();
            errors      = 0;
        endfunction

        function void load_prg_reset();
            logic [6:0] last_bank;
            last_bank    = prg_banks - 7'd1;
            map.prg_low  = '0;
            map.prg_high = (prg_banks >= LARGE_BANKS) ? 6'd15 : last_bank[5:0];
        endfunction

        function void configure(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_PRG_BANKS: begin
                    prg_banks = value;
                    load_prg_reset();
                end
                CFG_CHR_ROM:   chr_rom = value[0];
                CFG_WRAM_MODE: wram_mode = value[1:0];
                default: ;
            endcase
        endfunction

        function void map_chr();
            if (chr_rom) begin
                if (ctrl[4]) begin
                    map.chr_low  = bank_reg[REG_CHR_LOW];
                    map.chr_high = bank_reg[REG_CHR_HIGH];
                end else begin
                    map.chr_low  = {bank_reg[REG_CHR_LOW][4:1], 1'b0};
                    map.chr_high = bank_reg[REG_CHR_LOW] | 5'd1;
                end
            end else if (ctrl[4]) begin
                map.chr_low  = bank_reg[REG_CHR_LOW];
                map.chr_high = bank_reg[REG_CHR_HIGH];
            end
        endfunction

        // one accepted CPU write: update the state and queue the map it leaves
        function void note_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
            logic       large_cart;
            logic [1:0] region;
            logic [4:0] r3;
            logic [4:0] masked;
            logic [5:0] base;
            logic [6:0] last_bank;
            large_cart = prg_banks >= LARGE_BANKS;
            region     = addr[14:13];
            if (wram_mode == WRAM_COUNT && addr == WRAM_COUNT_ADDR) begin
                wram_hits = wram_hits + 3'd1;
                wram_sum  = wram_sum + 3'(data[0]);
                if (wram_hits == WRAM_WRITES) begin
                    map.wram  = wram_sum != 3'd0;
                    wram_hits = '0;
                    wram_sum  = '0;
                end
            end
            if (!large_cart) begin
                if (region != last_region) begin
                    shift_count = '0;
                    shift_value = '0;
                end
                last_region = region;
            end
            if (data[7]) begin
                shift_count = '0;
                shift_value = '0;
                ctrl        = ctrl | CTRL_RESET;
            end else begin
                if (data[0]) shift_value = shift_value | (5'd1 << shift_count);
                shift_count = shift_count + 3'd1;
                if (shift_count == SHIFT_LEN) begin
                    if (region == REG_CONTROL) ctrl = shift_value;
                    else bank_reg[region] = shift_value;
                    shift_value = '0;
                    shift_count = '0;
                    r3 = bank_reg[REG_PRG];
                    if (!large_cart) begin
                        case (region)
                            REG_CONTROL: map.mirror = ctrl[1:0];
                            REG_PRG: begin
                                if (!ctrl[3]) begin
                                    map.prg_low  = {1'b0, r3[4:1], 1'b0};
                                    map.prg_high = {1'b0, r3[4:1], 1'b1};
                                end else if (ctrl[2]) begin
                                    last_bank    = prg_banks - 7'd1;
                                    map.prg_low  = {1'b0, r3};
                                    map.prg_high = last_bank[5:0];
                                end else begin
                                    map.prg_low  = '0;
                                    map.prg_high = {1'b0, r3};
                                end
                            end
                            default: begin
                                // CHR RAM pages move one at a time, and only in 4K mode
                                if (chr_rom) begin
                                    map_chr();
                                end else if (ctrl[4]) begin
                                    if (region == REG_CHR_LOW) map.chr_low = bank_reg[region];
                                    else map.chr_high = bank_reg[region];
                                end
                            end
                        endcase
                    end else begin
                        // large carts: register 1 bit 4 picks the 256K half
                        base = {1'b0, bank_reg[REG_CHR_LOW][4], 4'd0};
                        if (wram_mode == WRAM_REG1) map.wram = |bank_reg[REG_CHR_LOW][4:3];
                        if (region == REG_CONTROL) map.mirror = ctrl[1:0];
                        map_chr();
                        if (!ctrl[3]) begin
                            masked       = r3 & {bank_reg[REG_CHR_LOW][4], 4'hF};
                            map.prg_low  = {1'b0, masked[4:1], 1'b0};
                            map.prg_high = {1'b0, masked[4:1], 1'b1};
                        end else if (ctrl[2]) begin
                            map.prg_low  = base + {2'b00, r3[3:0]};
                            map.prg_high = base + 6'd15;
                        end else begin
                            map.prg_low  = base;
                            map.prg_high = base + {2'b00, r3[3:0]};
                        end
                    end
                end
            end
            expected_maps.push_back(map);
        endfunction

        task report(string what, logic [31:0] want, logic [31:0] seen);
            errors++;
            $display("mismatch %s: expected %0h, got %0h", what, want, seen);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] got);
            t_map e;
            if (expected_maps.size() == 0) begin
                report("unexpected result transaction", '0, got);
                return;
            end
            e = expected_maps.pop_front();
            if (got[5:0] !== e.prg_low)
                report("prg_bank_low", 32'(e.prg_low), 32'(got[5:0]));
            if (got[11:6] !== e.prg_high)
                report("prg_bank_high", 32'(e.prg_high), 32'(got[11:6]));
            if (got[16:12] !== e.chr_low)
                report("chr_bank_low", 32'(e.chr_low), 32'(got[16:12]));
            if (got[21:17] !== e.chr_high)
                report("chr_bank_high", 32'(e.chr_high), 32'(got[21:17]));
            if (got[23:22] !== e.mirror)
                report("mirroring", 32'(e.mirror), 32'(got[23:22]));
            if (got[24] !== e.wram)
                report("wram_page", 32'(e.wram), 32'(got[24]));
        endtask

        function int pending();
            return expected_maps.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    bank_map_scoreboard sb;
    int items_sent;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_left;

    // per-phase configuration; phase 0 runs on the reset values
    int phase_banks [N_PHASES] = '{8, 2, 64, 32, 31, 16, 40, 8};
    int phase_chr   [N_PHASES] = '{1, 1, 0, 1, 0, 0, 1, 0};
    int phase_wram  [N_PHASES] = '{0, 1, 2, 2, 1, 3, 1, 0};

    serial_bank_switch_mapper uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic send_item(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_write(addr, data);
        items_sent++;
    endtask

    // five serial writes, LSB first, loading one internal register
    task automatic send_serial(input logic [ADDR_W-1:0] addr, input logic [4:0] value);
        for (int i = 0; i < 5; i++) send_item(addr, {1'b0, 6'($urandom), value[i]});
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.configure(index, value);
    endtask

    task automatic run_random(input int upto);
        int                kind;
        logic [1:0]        region;
        logic [ADDR_W-1:0] addr;
        while (items_sent < upto) begin
            kind   = $urandom_range(0, 99);
            region = 2'($urandom);
            addr   = {1'b1, region, 13'($urandom)};
            if (kind < 8) begin
                if ($urandom_range(0, 7) == 0) addr = 16'($urandom);
                send_item(addr, 8'($urandom));
            end else if (kind < 14) begin
                send_item(addr, {1'b1, 7'($urandom)});
            end else if (kind < 22) begin
                // broken sequence, left for a later write to clear or finish
                repeat ($urandom_range(1, 4)) send_item(addr, {1'b0, 7'($urandom)});
            end else if (kind < 34) begin
                repeat (5) send_item(WRAM_COUNT_ADDR, {1'($urandom_range(0, 9) == 0),
                                                       6'($urandom),
                                                       1'($urandom_range(0, 3) == 0)});
            end else begin
                send_serial(addr, 5'($urandom));
            end
        end
    endtask

    // result side: checks each transaction and drives the stall pattern
    initial begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= $urandom_range(0, 99) >= recv_stall_pct;
            end
        end
    end

    initial begin
        sb             = new();
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                while (sb.pending() != 0) @(posedge i_clk);
                if (p == 5) cfg_write(CFG_BAD_INDEX, 7'($urandom));
                cfg_write(CFG_PRG_BANKS, 7'(phase_banks[p]));
                cfg_write(CFG_CHR_ROM, {6'($urandom), 1'(phase_chr[p])});
                cfg_write(CFG_WRAM_MODE, {5'($urandom), 2'(phase_wram[p])});
                i_cfg_valid <= 1'b0;
            end
            send_idle_pct  = (p % 4 == 1) ? 59 : (p % 4 == 3) ? 13 : 0;
            recv_stall_pct = (p % 4 == 2) ? 59 : (p % 4 == 3) ? 13 : 0;
            if (p == 2 || p == 6) hold_request = 300;
            if (p == 0) begin
                send_item(16'hFFFF, 8'hFF);
                send_serial(16'h8000, 5'h10);       // 4K CHR, 32K PRG
                send_serial(16'hA000, 5'h1F);
                // region change part way through drops the partial value
                send_item(16'hC000, 8'h01);
                send_item(16'hC000, 8'h00);
                send_serial(16'hE000, 5'h0A);
                send_item(16'h8000, 8'h00);
                send_item(16'h8000, 8'h80);         // back to fixed-last PRG mode
                send_serial(16'hE000, 5'h1F);
            end
            run_random((p + 1) * PHASE_ITEMS);
            s_axis_tvalid <= 1'b0;
        end

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
